[hdl/lobm_pkg.sv]
// Shared types and codes for the limit order book matcher.
package lobm_pkg;

   localparam logic [2:0] ST_NEW     = 3'd0;
   localparam logic [2:0] ST_REJECT  = 3'd1;
   localparam logic [2:0] ST_FILL    = 3'd2;
   localparam logic [2:0] ST_PARTIAL = 3'd3;
   localparam logic [2:0] ST_FULL    = 3'd4;

   typedef struct packed {
      logic [15:0] tag;
      logic [31:0] num;
      logic [31:0] price;
      logic [15:0] qty;
   } entry_type;

   typedef struct packed {
      logic [15:0] client_tag;
      logic [2:0]  instrument;
      logic        side;
      logic [31:0] limit_price;
      logic [15:0] order_qty;
      logic        rejected;
      logic [3:0]  reject_code;
   } order_type;

   typedef struct packed {
      logic [15:0] client;
      logic [31:0] order_number;
      logic [2:0]  instrument;
      logic        side;
      logic [31:0] price;
      logic [15:0] qty;
      logic [2:0]  status;
      logic [3:0]  reason;
   } report_type;

   typedef struct packed {
      logic push;
      logic flush;
   } rq_ctl_type;

   typedef struct packed {
      logic push_ok;
      logic flush_ok;
   } rq_sts_type;

endpackage

[hdl/lobm_ifs.sv]
// Request and report channel interfaces.
interface lobm_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] client_tag;
   logic [2:0]  instrument;
   logic        side;
   logic [31:0] limit_price;
   logic [15:0] order_qty;
   logic        rejected;
   logic [3:0]  reject_code;
   modport source (output valid, client_tag, instrument, side, limit_price, order_qty,
                   rejected, reject_code, input ready);
   modport sink (input valid, client_tag, instrument, side, limit_price, order_qty,
                 rejected, reject_code, output ready);
endinterface

interface lobm_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] report_client;
   logic [31:0] report_order_number;
   logic [2:0]  report_instrument;
   logic        report_side;
   logic [31:0] report_price;
   logic [15:0] report_qty;
   logic [2:0]  report_status;
   logic [3:0]  report_reason;
   logic        last_report;
   modport source (output valid, report_client, report_order_number, report_instrument,
                   report_side, report_price, report_qty, report_status, report_reason,
                   last_report, input ready);
   modport sink (input valid, report_client, report_order_number, report_instrument,
                 report_side, report_price, report_qty, report_status, report_reason,
                 last_report, output ready);
endinterface

[hdl/lobm_book_mem.sv]
// Book entry memory: one write port, one registered read port.
module lobm_book_mem #(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = 8
) (
   input  logic                clock,
   input  logic                we,
   input  logic [ADDR_W-1:0]   waddr,
   input  lobm_pkg::entry_type wdata,
   input  logic                re,
   input  logic [ADDR_W-1:0]   raddr,
   output lobm_pkg::entry_type rdata
);

   lobm_pkg::entry_type mem [DEPTH];
   lobm_pkg::entry_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[hdl/lobm_report_q.sv]
// Report staging: holds one report back until it is known whether it is last.
module lobm_report_q (
   input  logic                 clock,
   input  logic                 reset,
   input  lobm_pkg::rq_ctl_type ctl,
   input  lobm_pkg::report_type push_data,
   output lobm_pkg::rq_sts_type sts,
   lobm_rsp_if.source           rsp_chan
);

   logic                 out_v_ff, out_v_in;
   lobm_pkg::report_type out_ff, out_in;
   logic                 out_last_ff, out_last_in;
   logic                 pend_v_ff, pend_v_in;
   lobm_pkg::report_type pend_ff, pend_in;
   logic                 can_out;

   assign can_out = !out_v_ff || rsp_chan.ready;
   assign sts.push_ok  = !pend_v_ff || can_out;
   assign sts.flush_ok = !pend_v_ff || can_out;

   always_comb begin
      out_v_in    = out_v_ff && !rsp_chan.ready;
      out_in      = out_ff;
      out_last_in = out_last_ff;
      pend_v_in   = pend_v_ff;
      pend_in     = pend_ff;
      if (ctl.push && sts.push_ok) begin
         if (pend_v_ff) begin
            out_v_in    = 1'b1;
            out_in      = pend_ff;
            out_last_in = 1'b0;
         end
         pend_in   = push_data;
         pend_v_in = 1'b1;
      end else if (ctl.flush && pend_v_ff && can_out) begin
         out_v_in    = 1'b1;
         out_in      = pend_ff;
         out_last_in = 1'b1;
         pend_v_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         pend_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         pend_v_ff <= pend_v_in;
      end
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
      pend_ff     <= pend_in;
   end

   assign rsp_chan.valid               = out_v_ff;
   assign rsp_chan.report_client       = out_ff.client;
   assign rsp_chan.report_order_number = out_ff.order_number;
   assign rsp_chan.report_instrument   = out_ff.instrument;
   assign rsp_chan.report_side         = out_ff.side;
   assign rsp_chan.report_price        = out_ff.price;
   assign rsp_chan.report_qty          = out_ff.qty;
   assign rsp_chan.report_status       = out_ff.status;
   assign rsp_chan.report_reason       = out_ff.reason;
   assign rsp_chan.last_report         = out_last_ff;

endmodule

[hdl/limit_order_book_matcher.sv]
// Limit order book matcher: sequencer over the book memory, top level.
//
// Channels: req_chan takes one limit order per request (valid/ready), rsp_chan
// gives the execution reports of that order, the final one flagged last_report.
// Order numbers start at one after reset and step once per request, rejects too.
// Every book lives in one memory with registered reads; entry counts per book
// sit in flops cleared at reset. Reset empties all books at once.
// One order at a time: ready is high only between orders.
// Work per order: a zero quantity goes straight back to idle with no report; a
// reject sends one report; otherwise each trade sends two reports, a filled
// resting entry leaves by moving the entries behind it up (up to BOOK_DEPTH-1
// moves), and insertion moves entries down (up to BOOK_DEPTH-1).
// Each memory move is a read followed by a write on the single port pair.
// Reports go through a one-deep hold stage (to mark the last one) and an output
// register. A stalled receiver stops the sequencer only when it must push a
// report while both stages are full; a new request can be taken while the final
// report still waits in the output register.
module limit_order_book_matcher #(
   parameter int INSTRUMENTS = 8,
   parameter int BOOK_DEPTH  = 16
) (
   input  logic      clock,
   input  logic      reset,
   lobm_req_if.sink   req_chan,
   lobm_rsp_if.source rsp_chan
);

   localparam int BOOKS = INSTRUMENTS * 2;
   localparam int BKW   = (BOOKS > 1) ? $clog2(BOOKS) : 1;
   localparam int SW    = $clog2(BOOK_DEPTH);
   localparam int CW    = $clog2(BOOK_DEPTH + 1);
   localparam int MEMD  = BOOKS * BOOK_DEPTH;
   localparam int AW    = $clog2(MEMD);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_REJ    = 4'd1;
   localparam logic [3:0] S_MRD    = 4'd2;
   localparam logic [3:0] S_MCHK   = 4'd3;
   localparam logic [3:0] S_REST   = 4'd4;
   localparam logic [3:0] S_SHRD   = 4'd5;
   localparam logic [3:0] S_SHWR   = 4'd6;
   localparam logic [3:0] S_INST   = 4'd7;
   localparam logic [3:0] S_INRD   = 4'd8;
   localparam logic [3:0] S_INCHK  = 4'd9;
   localparam logic [3:0] S_FLUSH  = 4'd10;

   logic [3:0]          state_ff, state_in;
   lobm_pkg::order_type ord_ff, ord_in;
   logic [31:0]         num_ff, num_in;
   logic [31:0]         seq_ff, seq_in;
   logic [15:0]         left_ff, left_in;
   logic [BKW-1:0]      bsel_ff, bsel_in;
   logic [CW-1:0]       idx_ff, idx_in;
   lobm_pkg::entry_type best_ff, best_in;
   logic [15:0]         rq_ff, rq_in;
   logic [15:0]         tq_ff, tq_in;
   logic [CW-1:0]       cnt_ff [BOOKS];
   logic                cnt_we;
   logic [CW-1:0]       cnt_wval;

   logic                 we, re;
   logic [AW-1:0]        waddr, raddr;
   lobm_pkg::entry_type  wdata, rdata;
   lobm_pkg::rq_ctl_type rq_ctl;
   lobm_pkg::rq_sts_type rq_sts;
   lobm_pkg::report_type rpt;

   logic [CW-1:0]       cur_cnt;
   logic                acc;
   logic                bad;
   logic [BKW-1:0]      own_bk, opp_bk;
   logic                crossed, stay;
   logic [15:0]         tq_c;
   lobm_pkg::entry_type new_ent;

   function automatic logic [AW-1:0] mk_addr(logic [BKW-1:0] bk, logic [CW-1:0] slot);
      logic [AW+CW-1:0] a;
      a = (AW+CW)'(bk) * (AW+CW)'(BOOK_DEPTH) + (AW+CW)'(slot[SW-1:0]);
      return a[AW-1:0];
   endfunction

   lobm_book_mem #(.DEPTH(MEMD), .ADDR_W(AW)) u_mem (
      .clock(clock), .we(we), .waddr(waddr), .wdata(wdata),
      .re(re), .raddr(raddr), .rdata(rdata)
   );

   lobm_report_q u_rq (
      .clock(clock), .reset(reset), .ctl(rq_ctl), .push_data(rpt),
      .sts(rq_sts), .rsp_chan(rsp_chan)
   );

   assign req_chan.ready = (state_ff == S_IDLE);
   assign acc     = req_chan.valid && req_chan.ready;
   assign cur_cnt = cnt_ff[bsel_ff];
   assign own_bk  = BKW'({ord_ff.instrument, ord_ff.side});
   assign opp_bk  = BKW'({ord_ff.instrument, ~ord_ff.side});
   assign bad     = req_chan.rejected || (int'(req_chan.instrument) >= INSTRUMENTS);

   // buy crosses when the best ask is not above the limit, sell the mirror case
   assign crossed = ord_ff.side ? (ord_ff.limit_price >= rdata.price)
                                : (ord_ff.limit_price <= rdata.price);
   // resting entry keeps its place ahead of the new one (equal price stays ahead)
   assign stay    = ord_ff.side ? (rdata.price >= ord_ff.limit_price)
                                : (rdata.price <= ord_ff.limit_price);
   assign tq_c    = (left_ff < rdata.qty) ? left_ff : rdata.qty;

   always_comb begin
      new_ent.tag   = ord_ff.client_tag;
      new_ent.num   = num_ff;
      new_ent.price = ord_ff.limit_price;
      new_ent.qty   = left_ff;
   end

   always_comb begin
      state_in = state_ff;
      ord_in   = ord_ff;
      num_in   = num_ff;
      seq_in   = seq_ff;
      left_in  = left_ff;
      bsel_in  = bsel_ff;
      idx_in   = idx_ff;
      best_in  = best_ff;
      rq_in    = rq_ff;
      tq_in    = tq_ff;
      cnt_we   = 1'b0;
      cnt_wval = cur_cnt;
      we       = 1'b0;
      waddr    = mk_addr(bsel_ff, '0);
      wdata    = new_ent;
      re       = 1'b0;
      raddr    = mk_addr(bsel_ff, '0);
      rq_ctl   = '0;
      rpt.client       = ord_ff.client_tag;
      rpt.order_number = num_ff;
      rpt.instrument   = ord_ff.instrument;
      rpt.side         = ord_ff.side;
      rpt.price        = ord_ff.limit_price;
      rpt.qty          = ord_ff.order_qty;
      rpt.status       = lobm_pkg::ST_NEW;
      rpt.reason       = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (acc) begin
               ord_in.client_tag  = req_chan.client_tag;
               ord_in.instrument  = req_chan.instrument;
               ord_in.side        = req_chan.side;
               ord_in.limit_price = req_chan.limit_price;
               ord_in.order_qty   = req_chan.order_qty;
               ord_in.rejected    = req_chan.rejected;
               ord_in.reject_code = req_chan.reject_code;
               num_in  = seq_ff;
               seq_in  = seq_ff + 32'd1;
               left_in = req_chan.order_qty;
               bsel_in = BKW'({req_chan.instrument, ~req_chan.side});
               if (bad) begin
                  state_in = S_REJ;
               end else if (req_chan.order_qty == 16'd0) begin
                  state_in = S_IDLE;
               end else begin
                  state_in = S_MRD;
               end
            end
         end
         S_REJ: begin
            rq_ctl.push = 1'b1;
            rpt.status  = lobm_pkg::ST_REJECT;
            rpt.reason  = ord_ff.reject_code;
            if (rq_sts.push_ok) begin
               state_in = S_FLUSH;
            end
         end
         S_MRD: begin
            if (left_ff == 16'd0 || cur_cnt == '0) begin
               bsel_in  = own_bk;
               state_in = S_INST;
            end else begin
               re       = 1'b1;
               state_in = S_MCHK;
            end
         end
         S_MCHK: begin
            if (!crossed) begin
               bsel_in  = own_bk;
               state_in = S_INST;
            end else begin
               rq_ctl.push = 1'b1;
               rpt.price   = rdata.price;
               rpt.qty     = tq_c;
               rpt.status  = (left_ff == tq_c) ? lobm_pkg::ST_FILL : lobm_pkg::ST_PARTIAL;
               if (rq_sts.push_ok) begin
                  left_in  = left_ff - tq_c;
                  best_in  = rdata;
                  tq_in    = tq_c;
                  rq_in    = rdata.qty - tq_c;
                  state_in = S_REST;
               end
            end
         end
         S_REST: begin
            rq_ctl.push      = 1'b1;
            rpt.client       = best_ff.tag;
            rpt.order_number = best_ff.num;
            rpt.side         = ~ord_ff.side;
            rpt.price        = best_ff.price;
            rpt.qty          = tq_ff;
            rpt.status       = (rq_ff == 16'd0) ? lobm_pkg::ST_FILL : lobm_pkg::ST_PARTIAL;
            if (rq_sts.push_ok) begin
               if (rq_ff == 16'd0) begin
                  idx_in   = CW'(1);
                  state_in = S_SHRD;
               end else begin
                  we        = 1'b1;
                  wdata     = best_ff;
                  wdata.qty = rq_ff;
                  state_in  = S_MRD;
               end
            end
         end
         S_SHRD: begin
            if (idx_ff < cur_cnt) begin
               re       = 1'b1;
               raddr    = mk_addr(bsel_ff, idx_ff);
               state_in = S_SHWR;
            end else begin
               cnt_we   = 1'b1;
               cnt_wval = cur_cnt - CW'(1);
               state_in = S_MRD;
            end
         end
         S_SHWR: begin
            we       = 1'b1;
            waddr    = mk_addr(bsel_ff, idx_ff - CW'(1));
            wdata    = rdata;
            idx_in   = idx_ff + CW'(1);
            state_in = S_SHRD;
         end
         S_INST: begin
            idx_in = cur_cnt;
            if (left_ff == 16'd0) begin
               state_in = S_FLUSH;
            end else if (int'(cur_cnt) >= BOOK_DEPTH) begin
               rq_ctl.push = 1'b1;
               rpt.qty     = left_ff;
               rpt.status  = lobm_pkg::ST_FULL;
               if (rq_sts.push_ok) begin
                  state_in = S_FLUSH;
               end
            end else if (left_ff == ord_ff.order_qty) begin
               rq_ctl.push = 1'b1;
               if (rq_sts.push_ok) begin
                  state_in = S_INRD;
               end
            end else begin
               state_in = S_INRD;
            end
         end
         S_INRD: begin
            if (idx_ff == '0) begin
               we       = 1'b1;
               cnt_we   = 1'b1;
               cnt_wval = cur_cnt + CW'(1);
               state_in = S_FLUSH;
            end else begin
               re       = 1'b1;
               raddr    = mk_addr(bsel_ff, idx_ff - CW'(1));
               state_in = S_INCHK;
            end
         end
         S_INCHK: begin
            we    = 1'b1;
            waddr = mk_addr(bsel_ff, idx_ff);
            if (stay) begin
               cnt_we   = 1'b1;
               cnt_wval = cur_cnt + CW'(1);
               state_in = S_FLUSH;
            end else begin
               wdata    = rdata;
               idx_in   = idx_ff - CW'(1);
               state_in = S_INRD;
            end
         end
         S_FLUSH: begin
            rq_ctl.flush = 1'b1;
            if (rq_sts.flush_ok) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         seq_ff   <= 32'd1;
         for (int i = 0; i < BOOKS; i++) begin
            cnt_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         seq_ff   <= seq_in;
         if (cnt_we) begin
            cnt_ff[bsel_ff] <= cnt_wval;
         end
      end
      ord_ff  <= ord_in;
      num_ff  <= num_in;
      left_ff <= left_in;
      bsel_ff <= bsel_in;
      idx_ff  <= idx_in;
      best_ff <= best_in;
      rq_ff   <= rq_in;
      tq_ff   <= tq_in;
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      int'(cur_cnt) <= BOOK_DEPTH)
      else $error("book count above depth");

   a_seq_step: assert property (@(posedge clock) disable iff (reset)
      acc |=> (seq_ff == $past(seq_ff) + 32'd1))
      else $error("order number did not step on request");

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (!we && !cnt_we))
      else $error("book written while idle");

endmodule

[verif/lobm_tb_ifs_note.sv]
// Testbench helper types for the order book matcher scoreboard.
package lobm_tb_pkg;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_INSTR  = 8;
   localparam int BOOK_SLOTS = 16;

   typedef struct {
      lobm_pkg::report_type rpt;
      logic                 last;
   } expected_report_type;

   // Book model plus queue of expected reports.
   class report_scoreboard;
      lobm_pkg::entry_type books[NUM_INSTR*2][BOOK_SLOTS];
      int                  depth_of[NUM_INSTR*2];
      logic [31:0]         next_number;
      expected_report_type pending[$];
      int                  errors;

      function new();
         foreach (depth_of[i]) depth_of[i] = 0;
         next_number = 32'd1;
         errors = 0;
      endfunction

      function void push_report(logic [15:0] tag, logic [31:0] num, logic [2:0] ins,
                                logic sd, logic [31:0] px, logic [15:0] q,
                                logic [2:0] st, logic [3:0] rsn);
         expected_report_type e;
         e.rpt = '{client: tag, order_number: num, instrument: ins, side: sd,
                   price: px, qty: q, status: st, reason: rsn};
         e.last = 1'b0;
         pending.insert(pending.size(), e);
      endfunction

      function void note_order(lobm_pkg::order_type o);
         logic [31:0] num;
         logic [15:0] left, tq;
         int own, opp, cnt, pos, n0;
         lobm_pkg::entry_type best;
         num = next_number;
         next_number = next_number + 32'd1;
         n0 = pending.size();
         if (o.rejected || o.instrument >= NUM_INSTR) begin
            push_report(o.client_tag, num, o.instrument, o.side, o.limit_price,
                        o.order_qty, lobm_pkg::ST_REJECT, o.reject_code);
         end else begin
            own = o.instrument * 2 + o.side;
            opp = o.instrument * 2 + (1 - o.side);
            left = o.order_qty;
            while (left != 0 && depth_of[opp] > 0) begin
               best = books[opp][0];
               if (o.side ? (o.limit_price < best.price) : (o.limit_price > best.price))
                  break;
               tq = (left < best.qty) ? left : best.qty;
               left = left - tq;
               best.qty = best.qty - tq;
               books[opp][0] = best;
               push_report(o.client_tag, num, o.instrument, o.side, best.price, tq,
                           left == 0 ? lobm_pkg::ST_FILL : lobm_pkg::ST_PARTIAL, 4'd0);
               push_report(best.tag, best.num, o.instrument, ~o.side, best.price, tq,
                           best.qty == 0 ? lobm_pkg::ST_FILL : lobm_pkg::ST_PARTIAL,
                           4'd0);
               if (best.qty == 0) begin
                  for (int i = 0; i < depth_of[opp] - 1; i++)
                     books[opp][i] = books[opp][i+1];
                  depth_of[opp]--;
               end
            end
            if (left != 0) begin
               cnt = depth_of[own];
               if (cnt >= BOOK_SLOTS) begin
                  push_report(o.client_tag, num, o.instrument, o.side, o.limit_price,
                              left, lobm_pkg::ST_FULL, 4'd0);
               end else begin
                  if (left == o.order_qty)
                     push_report(o.client_tag, num, o.instrument, o.side,
                                 o.limit_price, o.order_qty, lobm_pkg::ST_NEW, 4'd0);
                  pos = 0;
                  while (pos < cnt && (o.side ? (books[own][pos].price >= o.limit_price)
                                              : (books[own][pos].price <= o.limit_price)))
                     pos++;
                  for (int i = cnt; i > pos; i--) books[own][i] = books[own][i-1];
                  books[own][pos] = '{tag: o.client_tag, num: num,
                                      price: o.limit_price, qty: left};
                  depth_of[own] = cnt + 1;
               end
            end
         end
         if (pending.size() > n0) pending[pending.size()-1].last = 1'b1;
      endfunction

      function void check_report(lobm_pkg::report_type got, logic got_last);
         expected_report_type e;
         if (pending.size() == 0) begin
            $error("report with nothing expected: order %0d", got.order_number);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.client !== e.rpt.client) begin
            $error("report_client exp %0h got %0h", e.rpt.client, got.client); errors++;
         end
         if (got.order_number !== e.rpt.order_number) begin
            $error("report_order_number exp %0d got %0d", e.rpt.order_number,
                   got.order_number); errors++;
         end
         if (got.instrument !== e.rpt.instrument) begin
            $error("report_instrument exp %0d got %0d", e.rpt.instrument,
                   got.instrument); errors++;
         end
         if (got.side !== e.rpt.side) begin
            $error("report_side exp %0d got %0d", e.rpt.side, got.side); errors++;
         end
         if (got.price !== e.rpt.price) begin
            $error("report_price exp %0d got %0d", e.rpt.price, got.price); errors++;
         end
         if (got.qty !== e.rpt.qty) begin
            $error("report_qty exp %0d got %0d", e.rpt.qty, got.qty); errors++;
         end
         if (got.status !== e.rpt.status) begin
            $error("report_status exp %0d got %0d", e.rpt.status, got.status); errors++;
         end
         if (got.reason !== e.rpt.reason) begin
            $error("report_reason exp %0d got %0d", e.rpt.reason, got.reason); errors++;
         end
         if (got_last !== e.last) begin
            $error("last_report exp %0d got %0d", e.last, got_last); errors++;
         end
      endfunction
   endclass
endpackage

[verif/testbench.sv]
// Top-level testbench for the limit order book matcher.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ORDERS = 290;
   localparam longint CYCLE_LIMIT = 2000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   longint cycle_count = 0;

   lobm_req_if req_chan ();
   lobm_rsp_if rsp_chan ();

   limit_order_book_matcher u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   lobm_tb_pkg::report_scoreboard fills = new();
   bit  hold_rsp_open = 1'b0;  // receiver never stalls while set

   initial begin
      forever #5 clock = ~clock;
   end

   // Timeout guard.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Receiver: stall pattern from a free-running counter, toggling phases between
   // heavy stall, light stall and always ready.
   int unsigned stall_phase = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_phase <= 0;
      end else begin
         stall_phase <= stall_phase + 1;
         if (hold_rsp_open || stall_phase[9:8] == 2'd3)
            rsp_chan.ready <= 1'b1;
         else if (stall_phase[9:8] == 2'd1)
            rsp_chan.ready <= ($urandom_range(0, 3) == 0);
         else
            rsp_chan.ready <= ($urandom_range(0, 3) != 0);
      end
   end

   // Report monitor: compare every accepted report against the model.
   always @(posedge clock) begin
      lobm_pkg::report_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = '{client: rsp_chan.report_client,
                 order_number: rsp_chan.report_order_number,
                 instrument: rsp_chan.report_instrument,
                 side: rsp_chan.report_side, price: rsp_chan.report_price,
                 qty: rsp_chan.report_qty, status: rsp_chan.report_status,
                 reason: rsp_chan.report_reason};
         fills.check_report(got, rsp_chan.last_report);
      end
   end

   // Drive one order request; returns after it is accepted.
   task automatic send_order(lobm_pkg::order_type o);
      req_chan.valid       <= 1'b1;
      req_chan.client_tag  <= o.client_tag;
      req_chan.instrument  <= o.instrument;
      req_chan.side        <= o.side;
      req_chan.limit_price <= o.limit_price;
      req_chan.order_qty   <= o.order_qty;
      req_chan.rejected    <= o.rejected;
      req_chan.reject_code <= o.reject_code;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
      fills.note_order(o);
   endtask

   task automatic idle_cycles(int n);
      req_chan.valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   function automatic lobm_pkg::order_type make_order(logic [15:0] tag, logic [2:0] ins,
                                                      logic sd, logic [31:0] px,
                                                      logic [15:0] q, logic rj,
                                                      logic [3:0] code);
      lobm_pkg::order_type o;
      o = '{client_tag: tag, instrument: ins, side: sd, limit_price: px,
            order_qty: q, rejected: rj, reject_code: code};
      return o;
   endfunction

   // Random order: mostly well formed, prices clustered so books cross often.
   function automatic lobm_pkg::order_type random_order();
      lobm_pkg::order_type o;
      int unsigned pick;
      o.client_tag  = 16'($urandom);
      o.instrument  = 3'($urandom_range(0, 2));   // few instruments -> deep books
      if ($urandom_range(0, 15) == 0) o.instrument = 3'($urandom_range(0, 7));
      o.side        = 1'($urandom_range(0, 1));
      o.limit_price = 32'd1000 + $urandom_range(0, 12);
      pick = $urandom_range(0, 31);
      if (pick == 0) o.limit_price = 32'd0;
      else if (pick == 1) o.limit_price = 32'hFFFF_FFFF;
      else if (pick == 2) o.limit_price = $urandom;
      o.order_qty = 16'($urandom_range(1, 40));
      pick = $urandom_range(0, 31);
      if (pick == 0) o.order_qty = 16'd0;
      else if (pick == 1) o.order_qty = 16'hFFFF;
      else if (pick == 2) o.order_qty = 16'($urandom);
      o.rejected    = ($urandom_range(0, 19) == 0);
      o.reject_code = 4'($urandom);
      return o;
   endfunction

   initial begin
      req_chan.valid       = 1'b0;
      req_chan.client_tag  = '0;
      req_chan.instrument  = '0;
      req_chan.side        = 1'b0;
      req_chan.limit_price = '0;
      req_chan.order_qty   = '0;
      req_chan.rejected    = 1'b0;
      req_chan.reject_code = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: rejects, zero qty, extremes.
      send_order(make_order(16'hFFFF, 3'd0, 1'b1, 32'd100, 16'd5, 1'b1, 4'hF));
      send_order(make_order(16'h0000, 3'd7, 1'b0, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 4'h0));
      send_order(make_order(16'h1234, 3'd1, 1'b1, 32'd500, 16'd0, 1'b0, 4'h9));
      // Resting sells at equal price: time priority.
      send_order(make_order(16'h0001, 3'd1, 1'b0, 32'd200, 16'd10, 1'b0, 4'h0));
      send_order(make_order(16'h0002, 3'd1, 1'b0, 32'd200, 16'd10, 1'b0, 4'h0));
      send_order(make_order(16'h0003, 3'd1, 1'b0, 32'd150, 16'd4, 1'b0, 4'h0));
      // Buy sweeps: fill, partial fills, remainder rests.
      send_order(make_order(16'h0004, 3'd1, 1'b1, 32'd250, 16'd20, 1'b0, 4'h0));
      send_order(make_order(16'h0005, 3'd1, 1'b1, 32'd199, 16'd3, 1'b0, 4'h0));
      send_order(make_order(16'h0006, 3'd1, 1'b0, 32'd0, 16'hFFFF, 1'b0, 4'h0));
      // Fill one book of instrument 2 completely, then book-full.
      for (int i = 0; i < lobm_tb_pkg::BOOK_SLOTS + 2; i++)
         send_order(make_order(16'(16'h0100 + i), 3'd2, 1'b1, 32'(10 + (i % 3)),
                               16'd1, 1'b0, 4'h0));
      // Max-price sell that cannot match rests at top of the sell book.
      send_order(make_order(16'hBEEF, 3'd2, 1'b0, 32'hFFFF_FFFF, 16'd2, 1'b0, 4'h0));

      // Pause until every expected report has been seen.
      idle_cycles(1);
      while (fills.pending.size() != 0) @(posedge clock);

      // Random part: bursts with gaps, a drain pause in the middle.
      for (int n = 0; n < RANDOM_ORDERS; n++) begin
         send_order(random_order());
         if ($urandom_range(0, 5) == 0) idle_cycles($urandom_range(1, 20));
         if (n == RANDOM_ORDERS / 2) begin
            idle_cycles(1);
            while (fills.pending.size() != 0) @(posedge clock);
         end
      end
      req_chan.valid <= 1'b0;

      hold_rsp_open = 1'b1;
      while (fills.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);

      if (fills.errors == 0 && fills.pending.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
